@@ src/mbe_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_pkg: shared types and constants for the escape-time engine
// Fixed-point widths, register indexes, and the token handed cell to cell.
// ----------------------------------------------------------------------------
package mbe_pkg;

  localparam int FRAC_BITS  = 28;
  localparam int INDEX_BITS = 10;
  localparam int COUNT_BITS = 10;
  localparam int NUM_CELLS  = 4;

  localparam int REG_W = 32;
  localparam int IDX_W = 3;

  // z magnitude stays within 2.0 while live: sign + 2 integer bits
  localparam int ZW  = FRAC_BITS + 3;
  localparam int PW  = 2 * ZW;
  // col * step product and c = start + col * step
  localparam int PRW = INDEX_BITS + 1 + REG_W;
  localparam int CW  = PRW + 1;
  localparam int NW  = ((CW > FRAC_BITS + 4) ? CW : FRAC_BITS + 4) + 1;

  localparam logic signed [NW-1:0] Z_LIM   = NW'(2) << FRAC_BITS;
  localparam logic signed [NW-1:0] Z_LIM_N = -Z_LIM;
  localparam logic signed [PW-1:0] ESC_THR = PW'(1) << (2 * FRAC_BITS + 2);

  localparam logic [REG_W-1:0]      RST_START_X = 32'hE000_0000;
  localparam logic [REG_W-1:0]      RST_START_Y = 32'h2000_0000;
  localparam logic [REG_W-1:0]      RST_STEP_X  = 32'd1074764;
  localparam logic [REG_W-1:0]      RST_STEP_Y  = 32'hFFEF_99B4;
  localparam logic [COUNT_BITS-1:0] RST_MAX_IT  = COUNT_BITS'(255);

  typedef enum logic [IDX_W-1:0] {
    REG_START_X = 3'd0,
    REG_START_Y = 3'd1,
    REG_STEP_X  = 3'd2,
    REG_STEP_Y  = 3'd3,
    REG_MAX_IT  = 3'd4
  } mbe_reg_e;

  typedef struct packed {
    logic                    valid;
    logic                    big;
    logic [COUNT_BITS-1:0]   iter;
    logic signed [ZW-1:0]    zr;
    logic signed [ZW-1:0]    zi;
  } mbe_tok_t;

  typedef struct packed {
    logic                  fin;
    logic [COUNT_BITS-1:0] res;
  } mbe_fin_t;

endpackage

@@ src/mbe_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_cell: one iteration step of the ring
// Tests the incoming z for escape or the iteration limit, else forms z*z + c and hands it on.
// ----------------------------------------------------------------------------
module mbe_cell import mbe_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mbe_tok_t               tok_i,
  input  logic signed [CW-1:0]   cr_i,
  input  logic signed [CW-1:0]   ci_i,
  input  logic [COUNT_BITS-1:0]  max_iter_i,
  output mbe_tok_t               tok_o,
  output mbe_fin_t               fin_o
);

  logic signed [PW-1:0] sq_r, sq_i, xp, mag2, diff, re_w, im_w;
  logic signed [NW-1:0] nr, ni;
  logic                 esc, at_lim, stop;

  mbe_tok_t tok_q, tok_d;
  mbe_fin_t fin_q, fin_d;

  assign sq_r = PW'($signed(tok_i.zr)) * PW'($signed(tok_i.zr));
  assign sq_i = PW'($signed(tok_i.zi)) * PW'($signed(tok_i.zi));
  assign xp   = PW'($signed(tok_i.zr)) * PW'($signed(tok_i.zi));

  assign mag2   = sq_r + sq_i;
  assign esc    = tok_i.big || (mag2 > ESC_THR);
  assign at_lim = (tok_i.iter == max_iter_i);
  assign stop   = esc || at_lim;

  // floor scaling of the squares and doubled cross product
  assign diff = sq_r - sq_i;
  assign re_w = diff >>> FRAC_BITS;
  assign im_w = xp >>> (FRAC_BITS - 1);

  assign nr = NW'(re_w) + NW'(cr_i);
  assign ni = NW'(im_w) + NW'(ci_i);

  always_comb begin
    tok_d.valid = tok_i.valid && !stop;
    tok_d.big   = (nr > Z_LIM) || (nr < Z_LIM_N) || (ni > Z_LIM) || (ni < Z_LIM_N);
    tok_d.iter  = tok_i.iter + COUNT_BITS'(1);
    tok_d.zr    = ZW'(nr);
    tok_d.zi    = ZW'(ni);
    fin_d.fin   = tok_i.valid && stop;
    fin_d.res   = esc ? tok_i.iter : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
      fin_q <= '0;
    end else begin
      tok_q <= tok_d;
      fin_q <= fin_d;
    end
  end

  assign tok_o = tok_q;
  assign fin_o = fin_q;

endmodule

@@ src/mbe_outbuf.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mbe_outbuf: result register with one hold slot
// Catches a finished count while the previous one still waits downstream.
// ----------------------------------------------------------------------------
module mbe_outbuf import mbe_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mbe_fin_t               fin_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [COUNT_BITS-1:0]  count_o,
  output logic                   full_o
);

  logic                  out_v_q, out_v_d, hold_v_q, hold_v_d;
  logic [COUNT_BITS-1:0] out_c_q, out_c_d, hold_c_q, hold_c_d;
  logic                  take;

  assign take = !out_v_q || out_ready_i;

  always_comb begin
    out_v_d  = out_v_q;
    out_c_d  = out_c_q;
    hold_v_d = hold_v_q;
    hold_c_d = hold_c_q;
    if (take) begin
      if (hold_v_q) begin
        out_v_d  = 1'b1;
        out_c_d  = hold_c_q;
        hold_v_d = fin_i.fin;
        hold_c_d = fin_i.res;
      end else begin
        out_v_d = fin_i.fin;
        out_c_d = fin_i.res;
      end
    end else if (fin_i.fin) begin
      hold_v_d = 1'b1;
      hold_c_d = fin_i.res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      hold_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      hold_v_q <= hold_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_c_q  <= out_c_d;
    hold_c_q <= hold_c_d;
  end

  assign out_valid_o = out_v_q;
  assign count_o     = out_c_q;
  assign full_o      = hold_v_q;

endmodule

@@ src/mandelbrot_escape_time.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: escape-time iteration for one pixel per item
// Forms c from row/col and the view registers, then iterates z = z*z + c
// around a ring of cells, one iteration per cycle, and reports the count.
//
//   channel  signals                                  direction
//   in       in_valid_i/in_ready_o, row_i, col_i      sink
//   out      out_valid_o/out_ready_i, escape_count_o  source
//   cfg      cfg_we_i, cfg_idx_i, cfg_wdata_i         write only
//
// An item's count passes these steps: c and the inject flag are registered at
// the accepting edge, the ring does one iteration per cycle (max_iterations of
// them for a point that stays bounded), a cell tests the last z and registers
// its finish flag, and the output register then loads the count.
// One item is in the ring at a time; the next is taken once the previous one
// has finished and the hold slot is free. Reset is asynchronous and loads the
// default view; a stalled output does not stop the ring.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time import mbe_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [INDEX_BITS-1:0]  row_i,
  input  logic [INDEX_BITS-1:0]  col_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [COUNT_BITS-1:0]  escape_count_o,
  input  logic                   cfg_we_i,
  input  logic [IDX_W-1:0]       cfg_idx_i,
  input  logic [REG_W-1:0]       cfg_wdata_i
);

  logic [REG_W-1:0]      start_x_q, start_y_q, step_x_q, step_y_q;
  logic [COUNT_BITS-1:0] max_it_q;

  logic                  accept, busy_q, inj_q, hold_full;
  logic signed [PRW-1:0] prod_x, prod_y;
  logic signed [CW-1:0]  cr_q, ci_q, cr_d, ci_d;

  mbe_tok_t tok_in [NUM_CELLS];
  mbe_tok_t tok    [NUM_CELLS];
  mbe_fin_t fin    [NUM_CELLS];
  mbe_fin_t fin_any;
  mbe_tok_t tok_init;
  logic [2*NUM_CELLS:0] ring_act;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= RST_START_X;
      start_y_q <= RST_START_Y;
      step_x_q  <= RST_STEP_X;
      step_y_q  <= RST_STEP_Y;
      max_it_q  <= RST_MAX_IT;
    end else if (cfg_we_i) begin
      case (mbe_reg_e'(cfg_idx_i))
        REG_START_X: start_x_q <= cfg_wdata_i;
        REG_START_Y: start_y_q <= cfg_wdata_i;
        REG_STEP_X:  step_x_q  <= cfg_wdata_i;
        REG_STEP_Y:  step_y_q  <= cfg_wdata_i;
        REG_MAX_IT:  max_it_q  <= cfg_wdata_i[COUNT_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = !busy_q && !hold_full;
  assign accept     = in_valid_i && in_ready_o;

  assign prod_x = PRW'($signed({1'b0, col_i})) * PRW'($signed(step_x_q));
  assign prod_y = PRW'($signed({1'b0, row_i})) * PRW'($signed(step_y_q));
  assign cr_d   = CW'(prod_x) + CW'($signed(start_x_q));
  assign ci_d   = CW'(prod_y) + CW'($signed(start_y_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      inj_q  <= 1'b0;
    end else begin
      inj_q <= accept;
      if (accept) begin
        busy_q <= 1'b1;
      end else if (fin_any.fin) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cr_q <= cr_d;
      ci_q <= ci_d;
    end
  end

  always_comb begin
    tok_init.valid = inj_q;
    tok_init.big   = 1'b0;
    tok_init.iter  = '0;
    tok_init.zr    = '0;
    tok_init.zi    = '0;
  end

  assign tok_in[0] = inj_q ? tok_init : tok[NUM_CELLS-1];

  for (genvar k = 1; k < NUM_CELLS; k++) begin : g_link
    assign tok_in[k] = tok[k-1];
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    mbe_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .tok_i      (tok_in[k]),
      .cr_i       (cr_q),
      .ci_i       (ci_q),
      .max_iter_i (max_it_q),
      .tok_o      (tok[k]),
      .fin_o      (fin[k])
    );
  end

  // at most one cell finishes in a cycle
  always_comb begin
    fin_any = '0;
    for (int k = 0; k < NUM_CELLS; k++) begin
      if (fin[k].fin) begin
        fin_any.fin = 1'b1;
        fin_any.res = fin_any.res | fin[k].res;
      end
    end
  end

  mbe_outbuf u_outbuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .fin_i       (fin_any),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .count_o     (escape_count_o),
    .full_o      (hold_full)
  );

  always_comb begin
    ring_act[2*NUM_CELLS] = inj_q;
    for (int k = 0; k < NUM_CELLS; k++) begin
      ring_act[k]             = tok[k].valid;
      ring_act[NUM_CELLS + k] = fin[k].fin;
    end
  end

`ifndef SYNTHESIS
  a_single_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(ring_act))
    else $error("more than one item in the ring");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy_q && inj_q))
    else $error("accepted item not injected");

  a_hold_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fin_any.fin |-> !hold_full)
    else $error("result arrived with hold slot occupied");

  a_busy_no_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (busy_q && !fin_any.fin) |=> busy_q)
    else $error("busy dropped without a finished item");
`endif

endmodule
